[rtl/fbpa_pkg.sv]
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Shared codes, register indexes, state encoding and status struct.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

    localparam int ADDR_W    = 32;
    localparam int BYTES_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 16'd64;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CHECK,
        ST_POP_WAIT,
        ST_ADD,
        ST_DIV,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic empty;
        logic full;
    } stack_stat_t;

endpackage

`default_nettype wire

[rtl/fixed_block_pool_allocator_core.sv]
// ----------------------------------------------------------------------------
// Fixed block pool allocator core
// Hands out and takes back fixed-size blocks of a heap from a stack of free
// block indices kept in a synchronous memory.
// ----------------------------------------------------------------------------
// An allocate goes through the stack read, the stride multiply and the base
//   add before its result is loaded; a free that is pushed goes through the
//   serial divider, which makes one index bit per cycle.
// Throughput: one item at a time; the next item is taken the cycle after the
//   result is loaded into the output register, even if it is not yet taken.
// Reset: every block is free, heap_base is 0 and block_bytes is 64; no
//   clearing pass is needed because never-written stack entries read as
//   their own position.
`default_nettype none

module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 op,
    input  wire logic [ADDR_W-1:0]    addr,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [1:0]           status,
    output logic      [ADDR_W-1:0]    block_addr,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CAP_W  = $clog2(CAPACITY + 1);
    localparam int SPAN_W = CAP_W + BYTES_W;
    localparam int PROD_W = IDX_W + BYTES_W;
    localparam int CMP_W  = ADDR_W + 1;

    // Control state.
    state_t               state_reg;
    state_t               state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    // Configuration registers.
    logic [ADDR_W-1:0]    heap_base_reg;
    logic [BYTES_W-1:0]   block_bytes_reg;

    // Item and datapath registers.
    logic                 op_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    offset_reg;
    logic [SPAN_W-1:0]    span_reg;
    logic                 below_reg;
    logic [PROD_W-1:0]    prod_reg;
    status_t              res_status_reg;
    logic [ADDR_W-1:0]    res_addr_reg;
    status_t              status_reg;
    logic [ADDR_W-1:0]    block_addr_reg;

    // Sequencer outputs.
    logic                 accept;
    logic                 pop;
    logic                 push;
    logic                 div_start;
    logic                 load_out;
    logic                 res_we;
    status_t              res_status_val;
    logic [ADDR_W-1:0]    res_addr_val;

    logic                 range_bad;
    stack_stat_t          stk_stat;
    logic [IDX_W-1:0]     pop_idx;
    logic                 div_done;
    logic [IDX_W-1:0]     div_quot;

    fbpa_stack #(
        .CAPACITY (CAPACITY)
    ) u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .push     (push),
        .push_idx (div_quot),
        .pop_idx  (pop_idx),
        .stat     (stk_stat)
    );

    fbpa_div #(
        .QW (IDX_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (offset_reg),
        .divisor  (block_bytes_reg),
        .done     (div_done),
        .quot     (div_quot)
    );

    // A free is in range only when it lies at or above the base and its
    // offset is below CAPACITY blocks; a zero stride makes the span empty.
    assign range_bad = below_reg || (CMP_W'(offset_reg) >= CMP_W'(span_reg));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    state_next = stk_stat.empty ? ST_REPLY : ST_POP_WAIT;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (range_bad || stk_stat.full) ? ST_REPLY : ST_DIV;
            end
            ST_POP_WAIT:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ST_REPLY;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer.
    always_comb
    begin
        in_ready       = 1'b0;
        pop            = 1'b0;
        push           = 1'b0;
        div_start      = 1'b0;
        load_out       = 1'b0;
        res_we         = 1'b0;
        res_status_val = STAT_OK;
        res_addr_val   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_DECIDE:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (stk_stat.empty)
                    begin
                        res_we         = 1'b1;
                        res_status_val = STAT_EMPTY;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
            end
            ST_CHECK:
            begin
                if (range_bad)
                begin
                    res_we         = 1'b1;
                    res_status_val = STAT_RANGE;
                end
                else if (stk_stat.full)
                begin
                    res_we         = 1'b1;
                    res_status_val = STAT_FULL;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            ST_ADD:
            begin
                res_we       = 1'b1;
                res_addr_val = heap_base_reg + ADDR_W'(prod_reg);
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    push   = 1'b1;
                    res_we = 1'b1;
                end
            end
            ST_REPLY:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // The output register holds a finished result while the sequencer
    // already takes the next item.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            heap_base_reg   <= '0;
            block_bytes_reg <= BLOCK_BYTES_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HEAP_BASE:   heap_base_reg   <= cfg_data;
                    CFG_BLOCK_BYTES: block_bytes_reg <= cfg_data[BYTES_W-1:0];
                    default:         heap_base_reg   <= heap_base_reg;
                endcase
            end
        end
    end

    // Datapath registers. The range terms are registered ahead of the compare
    // so that the span multiply has a register after it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            addr_reg <= addr;
        end
        offset_reg <= addr_reg - heap_base_reg;
        below_reg  <= (addr_reg < heap_base_reg) || (block_bytes_reg == '0);
        span_reg   <= SPAN_W'(CAPACITY) * SPAN_W'(block_bytes_reg);
        prod_reg   <= PROD_W'(pop_idx) * PROD_W'(block_bytes_reg);
        if (res_we)
        begin
            res_status_reg <= res_status_val;
            res_addr_reg   <= res_addr_val;
        end
        if (load_out)
        begin
            status_reg     <= res_status_reg;
            block_addr_reg <= res_addr_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign block_addr = block_addr_reg;

`ifndef SYNTH
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stk_stat.empty)
        else $error("pop from an empty free stack");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stk_stat.full)
        else $error("push into a full free stack");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != STAT_OK) |-> (block_addr_reg == '0))
        else $error("failed item carries a nonzero block address");
`endif

endmodule

`default_nettype wire

[rtl/fbpa_stack.sv]
// ----------------------------------------------------------------------------
// Free index stack
// Synchronous stack memory with a fill count and a low-water mark; entries
// below the mark have never been written and read as their own position.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_stack
    import fbpa_pkg::*;
#(
    parameter int CAPACITY = 256,
    localparam int IDX_W = $clog2(CAPACITY),
    localparam int CNT_W = $clog2(CAPACITY + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pop,
    input  wire logic             push,
    input  wire logic [IDX_W-1:0] push_idx,
    output logic      [IDX_W-1:0] pop_idx,
    output stack_stat_t           stat
);

    logic [IDX_W-1:0] mem [CAPACITY];

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] low_reg;
    logic [CNT_W-1:0] low_next;
    logic [IDX_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] top_reg;
    logic             fresh_reg;
    logic [IDX_W-1:0] top_pos;
    logic [IDX_W-1:0] wr_pos;

    assign top_pos = IDX_W'(cnt_reg - CNT_W'(1));
    assign wr_pos  = cnt_reg[IDX_W-1:0];

    // The low-water mark is the smallest count ever reached. Every push lands
    // at or above it, so a pop that takes the count below it reads an entry
    // that has never been written, and its position is given out instead.
    always_comb
    begin
        cnt_next = cnt_reg;
        low_next = low_reg;
        if (pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == low_reg)
            begin
                low_next = cnt_reg - CNT_W'(1);
            end
        end
        else if (push)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_W'(CAPACITY);
            low_reg <= CNT_W'(CAPACITY);
        end
        else
        begin
            cnt_reg <= cnt_next;
            low_reg <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_pos] <= push_idx;
        end
        if (pop)
        begin
            rd_data_reg <= mem[top_pos];
            top_reg     <= top_pos;
            fresh_reg   <= (cnt_reg == low_reg);
        end
    end

    assign pop_idx    = fresh_reg ? top_reg : rd_data_reg;
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg >= CNT_W'(CAPACITY));

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("free count above capacity");

    a_low_mark: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (cnt_reg == low_reg) |=> (low_reg == cnt_reg))
        else $error("low-water mark did not follow a pop below it");
`endif

endmodule

`default_nettype wire

[rtl/fbpa_div.sv]
// ----------------------------------------------------------------------------
// Serial index divider
// Restoring division of a byte offset by the block stride, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_div
    import fbpa_pkg::*;
#(
    parameter int QW = 8,
    localparam int LW = $clog2(QW + 1)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [ADDR_W-1:0]  dividend,
    input  wire logic [BYTES_W-1:0] divisor,
    output logic                    done,
    output logic      [QW-1:0]      quot
);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [LW-1:0]     left_reg;
    logic [LW-1:0]     left_next;
    logic [ADDR_W-1:0] rem_reg;
    logic [ADDR_W-1:0] dsr_reg;
    logic [QW-1:0]     quot_reg;
    logic              ge;

    // The dividend is known to be below divisor * 2^QW, so QW steps suffice.
    assign ge = (rem_reg >= dsr_reg);

    always_comb
    begin
        busy_next = busy_reg;
        left_next = left_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            left_next = LW'(QW);
        end
        else if (busy_reg)
        begin
            left_next = left_reg - LW'(1);
            if (left_reg == LW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            dsr_reg  <= ADDR_W'(divisor) << (QW - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsr_reg;
            end
            dsr_reg  <= dsr_reg >> 1;
            quot_reg <= QW'({quot_reg, ge});
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

`ifndef SYNTH
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

[test/tb_fixed_block_pool_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the fixed block pool allocator core
// Drives allocate and free requests through the request channel, writes the
// heap base and block stride between phases, and checks every reply against
// a cycle-free model of the free-block stack kept inside the bench.
// ----------------------------------------------------------------------------

module tb_fixed_block_pool_allocator_core;
    import fbpa_pkg::*;

    localparam int POOL_SLOTS    = 256;
    localparam int IDX_W         = $clog2(POOL_SLOTS);
    localparam int RANDOM_ITEMS  = 1900;
    localparam int SETTLE_CYCLES = 3;
    localparam int HOLD_CYCLES   = 250;
    localparam int DRAIN_CYCLES  = 40;
    localparam int REPORT_LIMIT  = 10;

    // One reply as the core should produce it.
    typedef struct packed {
        status_t           st;
        logic [ADDR_W-1:0] ba;
    } pool_reply_t;

    // The stimulus plan mixes requests with a few control marks: a register
    // write (only issued once the core is idle), a pause until every reply is
    // back, and a request for a long hold-off on the reply side.
    typedef enum logic [1:0] {
        CMD_ITEM,
        CMD_CFG,
        CMD_SYNC,
        CMD_HOLD
    } plan_kind_t;

    typedef struct {
        plan_kind_t            kind;
        logic                  op;
        logic [ADDR_W-1:0]     addr;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [ADDR_W-1:0]     data;
    } plan_entry_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the core
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    logic                 op         = OP_ALLOC;
    logic [ADDR_W-1:0]    addr       = '0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    logic [1:0]           status;
    logic [ADDR_W-1:0]    block_addr;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = CFG_HEAP_BASE;
    logic [ADDR_W-1:0]    cfg_data   = '0;

    fixed_block_pool_allocator_core #(
        .CAPACITY (POOL_SLOTS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .addr       (addr),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .block_addr (block_addr),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    plan_entry_t stim_plan[$];
    pool_reply_t pool_replies[$];

    // Handshakes seen at the last rising edge; the driver and the reply side
    // look at these on the falling edge to decide what to do next.
    logic in_fired  = 1'b0;
    logic cfg_fired = 1'b0;
    logic out_fired = 1'b0;

    int hold_req = 0;

    // Our own copy of the free-block stack and the two registers.
    logic [IDX_W-1:0]   shadow_stack [POOL_SLOTS];
    int                 shadow_free;
    logic [ADDR_W-1:0]  shadow_base;
    logic [BYTES_W-1:0] shadow_bytes;

    int mismatch_cnt = 0;
    int n_checked    = 0;
    int n_alloc_ok   = 0;
    int n_free_ok    = 0;
    int n_empty      = 0;
    int n_range      = 0;
    int n_full       = 0;
    int n_cfg        = 0;

    // ------------------------------------------------------------------------
    // Pool model: works out the reply to one request and updates the stack.
    // ------------------------------------------------------------------------
    task automatic predict_pool_reply(input logic op_in, input logic [ADDR_W-1:0] a,
                                      output pool_reply_t r);
        logic [63:0]       span;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] slot;
        r.st = STAT_OK;
        r.ba = '0;
        span = 64'(POOL_SLOTS) * 64'(shadow_bytes);
        if (op_in == OP_ALLOC) begin
            if (shadow_free == 0) begin
                r.st = STAT_EMPTY;
            end else begin
                shadow_free = shadow_free - 1;
                slot = 32'(shadow_stack[shadow_free]);
                // Product and sum both wrap at 32 bits, as the core's adder does.
                r.ba = shadow_base + slot * 32'(shadow_bytes);
            end
        end else if (a < shadow_base || shadow_bytes == 0) begin
            // Below the base, or a zero stride that leaves the pool with no span.
            r.st = STAT_RANGE;
        end else begin
            off = a - shadow_base;
            if (64'(off) >= span) begin
                r.st = STAT_RANGE;
            end else if (shadow_free >= POOL_SLOTS) begin
                // The range check wins over the full check.
                r.st = STAT_FULL;
            end else begin
                // An address inside a block frees that block; double frees
                // are pushed again without complaint.
                shadow_stack[shadow_free] = IDX_W'(off / 32'(shadow_bytes));
                shadow_free = shadow_free + 1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Plan building helpers
    // ------------------------------------------------------------------------
    task automatic add_item(input logic o, input logic [ADDR_W-1:0] a);
        plan_entry_t e;
        e.kind    = CMD_ITEM;
        e.op      = o;
        e.addr    = a;
        e.reg_idx = CFG_HEAP_BASE;
        e.data    = '0;
        stim_plan.push_back(e);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] d);
        plan_entry_t e;
        e.kind    = CMD_CFG;
        e.op      = OP_ALLOC;
        e.addr    = '0;
        e.reg_idx = idx;
        e.data    = d;
        stim_plan.push_back(e);
    endtask

    task automatic add_mark(input plan_kind_t k);
        plan_entry_t e;
        e.kind    = k;
        e.op      = OP_ALLOC;
        e.addr    = '0;
        e.reg_idx = CFG_HEAP_BASE;
        e.data    = '0;
        stim_plan.push_back(e);
    endtask

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Free addresses are mostly real block addresses (sometimes pointing into
    // the middle of a block), plus the edges of the span and plain noise.
    function automatic logic [ADDR_W-1:0] make_free_addr(input logic [ADDR_W-1:0] b,
                                                         input logic [BYTES_W-1:0] s);
        logic [63:0] span;
        logic [63:0] a;
        int unsigned r;
        span = 64'(POOL_SLOTS) * 64'(s);
        r = $urandom_range(0, 99);
        if (r < 75) begin
            a = 64'(b) + 64'($urandom_range(0, POOL_SLOTS - 1)) * 64'(s);
            if (s != 0 && $urandom_range(0, 1) == 1)
                a = a + 64'($urandom_range(0, 32'(s) - 1));
        end else if (r < 80) begin
            a = 64'(b) - 64'd1;
        end else if (r < 85) begin
            a = 64'(b) + span;
        end else if (r < 90) begin
            a = 64'(b) + span - 64'd1;
        end else begin
            a = 64'($urandom);
        end
        return a[ADDR_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Request and register driver. Everything changes on the falling edge and
    // each output gets exactly one nonblocking update per edge, so a valid
    // that stays high for back-to-back items never glitches.
    // ------------------------------------------------------------------------
    int unsigned tx_gap    = 0;
    int unsigned tx_cycle  = 0;
    int unsigned quiet_cnt = 0;
    logic        tx_calm   = 1'b0;

    always @(negedge clk) begin : tx_drive
        logic                 nxt_valid;
        logic                 nxt_op;
        logic [ADDR_W-1:0]    nxt_addr;
        logic                 nxt_cfg_valid;
        logic [CFG_IDX_W-1:0] nxt_cfg_index;
        logic [ADDR_W-1:0]    nxt_cfg_data;
        int                   nxt_hold;
        nxt_valid     = in_valid;
        nxt_op        = op;
        nxt_addr      = addr;
        nxt_cfg_valid = cfg_valid;
        nxt_cfg_index = cfg_index;
        nxt_cfg_data  = cfg_data;
        nxt_hold      = hold_req;
        if (rst_n) begin
            tx_cycle++;
            // Every so often switch into or out of a stretch with no gaps.
            if (tx_cycle % 300 == 0)
                tx_calm = ($urandom_range(0, 3) == 0);
            if (in_valid && in_fired)
                nxt_valid = 1'b0;
            if (cfg_valid && cfg_fired)
                nxt_cfg_valid = 1'b0;
            // A register write waits until quiet_cnt shows the core has stayed idle.
            if (pool_replies.size() == 0 && !in_valid)
                quiet_cnt++;
            else
                quiet_cnt = 0;
            if (!nxt_valid && !nxt_cfg_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (stim_plan.size() > 0) begin
                    case (stim_plan[0].kind)
                        CMD_ITEM: begin
                            nxt_valid = 1'b1;
                            nxt_op    = stim_plan[0].op;
                            nxt_addr  = stim_plan[0].addr;
                            void'(stim_plan.pop_front());
                            tx_gap = tx_calm ? 0 : pick_gap();
                        end
                        CMD_CFG: begin
                            if (pool_replies.size() == 0 && quiet_cnt >= SETTLE_CYCLES) begin
                                nxt_cfg_valid = 1'b1;
                                nxt_cfg_index = stim_plan[0].reg_idx;
                                nxt_cfg_data  = stim_plan[0].data;
                                void'(stim_plan.pop_front());
                            end
                        end
                        CMD_SYNC: begin
                            if (pool_replies.size() == 0)
                                void'(stim_plan.pop_front());
                        end
                        default: begin
                            nxt_hold = hold_req + 1;
                            void'(stim_plan.pop_front());
                        end
                    endcase
                end
            end
        end
        in_valid  <= nxt_valid;
        op        <= nxt_op;
        addr      <= nxt_addr;
        cfg_valid <= nxt_cfg_valid;
        cfg_index <= nxt_cfg_index;
        cfg_data  <= nxt_cfg_data;
        hold_req  <= nxt_hold;
    end

    // ------------------------------------------------------------------------
    // Reply side: random stalls, calm stretches, and a long hold-off when the
    // plan asks for one so that the core backs up and stops taking requests.
    // ------------------------------------------------------------------------
    int unsigned rx_stall = 0;
    int unsigned rx_cycle = 0;
    int          hold_ack = 0;
    logic        rx_calm  = 1'b0;

    always @(negedge clk) begin : rx_drive
        logic nxt_ready;
        nxt_ready = out_ready;
        if (rst_n) begin
            rx_cycle++;
            if (rx_cycle % 256 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (hold_ack != hold_req) begin
                hold_ack = hold_req;
                rx_stall = HOLD_CYCLES;
            end
            if (rx_stall > 0) begin
                nxt_ready = 1'b0;
                rx_stall--;
            end else begin
                nxt_ready = 1'b1;
                if (!rx_calm && (out_fired || (!out_valid && $urandom_range(0, 9) == 0)))
                    rx_stall = pick_gap();
            end
        end
        out_ready <= nxt_ready;
    end

    // ------------------------------------------------------------------------
    // Monitor: on each rising edge record handshakes, update the register
    // copy, predict the reply to an accepted request, and check a taken reply
    // against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        pool_reply_t want;
        if (!rst_n) begin
            in_fired  <= 1'b0;
            cfg_fired <= 1'b0;
            out_fired <= 1'b0;
        end else begin
            in_fired  <= in_valid && in_ready;
            cfg_fired <= cfg_valid && cfg_ready;
            out_fired <= out_valid && out_ready;

            if (cfg_valid && cfg_ready) begin
                n_cfg++;
                case (cfg_index)
                    CFG_HEAP_BASE:   shadow_base  = cfg_data;
                    CFG_BLOCK_BYTES: shadow_bytes = cfg_data[BYTES_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready) begin
                predict_pool_reply(op, addr, want);
                case (want.st)
                    STAT_OK: begin
                        if (op == OP_ALLOC)
                            n_alloc_ok++;
                        else
                            n_free_ok++;
                    end
                    STAT_EMPTY: n_empty++;
                    STAT_RANGE: n_range++;
                    default:    n_full++;
                endcase
                pool_replies.push_back(want);
            end

            if (out_valid && out_ready) begin
                if (pool_replies.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                        $display("%0t: reply with nothing pending: status %0d block_addr %h",
                                 $time, status, block_addr);
                end else begin
                    want = pool_replies.pop_front();
                    n_checked++;
                    if (status !== want.st || block_addr !== want.ba) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_LIMIT)
                            $display("%0t: reply %0d: status exp %0d got %0d, %s %h got %h",
                                     $time, n_checked, want.st, status,
                                     "block_addr exp", want.ba, block_addr);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: build the plan, reset once, wait for everything to
    // drain, report.
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int unsigned       n_rand;
        int unsigned       phase;
        int unsigned       len;
        int unsigned       pct;
        int unsigned       j;
        int unsigned       pick;
        logic [ADDR_W-1:0] gen_base;
        logic [BYTES_W-1:0] gen_bytes;
        logic [ADDR_W-1:0] new_base;
        logic [BYTES_W-1:0] new_bytes;

        for (int i = 0; i < POOL_SLOTS; i++)
            shadow_stack[i] = IDX_W'(i);
        shadow_free  = POOL_SLOTS;
        shadow_base  = '0;
        shadow_bytes = BLOCK_BYTES_RST;

        // Directed part at the reset settings: base 0, 64-byte blocks.
        add_item(OP_FREE, 32'h0000_0000);       // valid address, stack already full
        add_item(OP_FREE, 32'hFFFF_FFFF);       // far outside the pool
        add_item(OP_ALLOC, 32'hFFFF_FFFF);      // address is ignored on allocate
        add_item(OP_ALLOC, 32'h0000_0000);
        add_item(OP_FREE, 32'd16383);           // last byte of the last block
        add_item(OP_FREE, 32'd16384);           // first byte past the span
        add_item(OP_ALLOC, 32'h5555_AAAA);
        add_item(OP_FREE, 32'd461);             // misaligned, inside block 7
        add_item(OP_FREE, 32'd448);             // same block again, not caught
        add_item(OP_FREE, 32'd0);               // stack full once more
        add_item(OP_ALLOC, 32'hAAAA_5555);
        add_item(OP_ALLOC, 32'h0000_0000);

        // Base near the top of the address space and the widest stride, so
        // allocated addresses wrap around.
        gen_base  = 32'hFFFF_FF00;
        gen_bytes = 16'hFFFF;
        add_cfg(CFG_HEAP_BASE, gen_base);
        add_cfg(CFG_BLOCK_BYTES, {16'hFFFF, gen_bytes});
        add_item(OP_ALLOC, 32'h0000_0000);
        add_item(OP_FREE, 32'h0000_0010);       // below the base
        add_item(OP_FREE, 32'hFFFF_FFFF);       // inside block 0
        add_item(OP_FREE, 32'hFFFF_FEFF);       // one byte below the base
        add_item(OP_ALLOC, 32'hFFFF_FFFF);

        // A zero stride leaves no span: frees are out of range and every
        // allocate answers the base itself.
        gen_bytes = 16'd0;
        add_cfg(CFG_BLOCK_BYTES, 32'(gen_bytes));
        add_item(OP_ALLOC, 32'h1234_5678);
        add_item(OP_FREE, gen_base);
        add_item(OP_ALLOC, 32'h0000_0000);

        // Random phases. The first three are fixed in shape: drain the pool
        // past empty, refill it past full, then run with both extremes of the
        // registers. After that every phase picks its own settings and mix.
        n_rand = 0;
        phase  = 0;
        while (n_rand < RANDOM_ITEMS) begin
            case (phase)
                0: begin
                    new_base = 32'h0; new_bytes = 16'd1; pct = 100; len = 280; pick = 3;
                end
                1: begin
                    new_base = 32'h8000_0000; new_bytes = 16'hFFFF; pct = 4; len = 420;
                    pick = 3;
                end
                2: begin
                    new_base = 32'hFFFF_FFFF; new_bytes = 16'hFFFF; pct = 50; len = 60;
                    pick = 3;
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0:       new_base = 32'h0;
                        1:       new_base = 32'hFFFF_FFFF;
                        2:       new_base = $urandom;
                        3:       new_base = $urandom & 32'hFFFF_F000;
                        default: new_base = 32'hFFFF_FFFF - $urandom_range(0, 4096);
                    endcase
                    case ($urandom_range(0, 9))
                        0:       new_bytes = 16'd1;
                        1:       new_bytes = 16'hFFFF;
                        2, 3:    new_bytes = 16'(1 << $urandom_range(0, 15));
                        4, 5, 6: new_bytes = 16'($urandom_range(1, 65535));
                        7, 8:    new_bytes = 16'($urandom_range(2, 40));
                        default: new_bytes = 16'd0;
                    endcase
                    case ($urandom_range(0, 4))
                        0:       pct = 5;
                        1:       pct = 30;
                        2:       pct = 50;
                        3:       pct = 70;
                        default: pct = 95;
                    endcase
                    len  = $urandom_range(40, 160);
                    pick = $urandom_range(1, 4);
                end
            endcase

            // Bit 0 of pick writes the base; bit 1, or a pick above 3, the stride.
            if (pick[0]) begin
                gen_base = new_base;
                add_cfg(CFG_HEAP_BASE, gen_base);
            end
            if (pick[1] || pick > 3) begin
                gen_bytes = new_bytes;
                add_cfg(CFG_BLOCK_BYTES, {16'($urandom), gen_bytes});
            end

            for (j = 0; j < len; j++) begin
                if (j == len / 2 && phase % 4 == 1)
                    add_mark(CMD_HOLD);
                if (j == len / 2 && phase % 4 == 3)
                    add_mark(CMD_SYNC);
                if ($urandom_range(1, 100) <= pct)
                    add_item(OP_ALLOC, $urandom);
                else
                    add_item(OP_FREE, make_free_addr(gen_base, gen_bytes));
            end
            n_rand += len;
            phase++;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stim_plan.size() != 0 || in_valid || cfg_valid || pool_replies.size() != 0)
            @(posedge clk);
        // Give a stray extra reply a chance to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests over %0d register writes: %0d allocations, %0d frees,",
                 n_checked, n_cfg, n_alloc_ok, n_free_ok);
        $display("%0d empty-pool, %0d out-of-range and %0d full-stack answers; %0d mismatches.",
                 n_empty, n_range, n_full, mismatch_cnt);
        if (mismatch_cnt == 0 && pool_replies.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            if (pool_replies.size() != 0)
                $display("%0d replies never arrived", pool_replies.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #15ms;
        $display("Timed out with %0d plan entries and %0d replies outstanding",
                 stim_plan.size(), pool_replies.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
